>>> rtl/mme_pkg.sv
`timescale 1ns / 1ps

package mme_pkg;

  localparam int MAX_DIM     = 8;
  localparam int FRAC_BITS   = 16;
  localparam int DIM_CAP     = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int VAL_W       = 32;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int ACC_W       = PROD_W + $clog2(MAX_DIM);
  localparam int IDX_W       = 3;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 2;

  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS     = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] product_value;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic                    last_element;
    logic                    saturated;
    logic                    index_error;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic sat;
  } mac_sts_t;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(DIM_CAP)) begin
      r = CFG_W'(DIM_CAP);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
  endfunction

endpackage

>>> rtl/mme_ram.sv
`timescale 1ns / 1ps

module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mme_mac.sv
`timescale 1ns / 1ps

module mme_mac import mme_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [VAL_W-1:0]  a_val,
  input  logic signed [VAL_W-1:0]  b_val,
  output mac_sts_t                 sts,
  output logic signed [VAL_W-1:0]  result
);

  localparam int UP_W = ACC_W - VAL_W + 1;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_sh;
  logic [UP_W-1:0]          upper;
  logic                     sat_pos;
  logic                     sat_neg;

  // multiply stage, then accumulate at full width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.valid;
    end
    prod_r <= a_val * b_val;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  always_comb begin
    acc_sh  = acc_r >>> FRAC_BITS;
    upper   = acc_sh[ACC_W-1:VAL_W-1];
    sat_pos = !acc_sh[ACC_W-1] && (|upper);
    sat_neg = acc_sh[ACC_W-1] && !(&upper);
    if (sat_pos) begin
      result = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sat_neg) begin
      result = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      result = acc_sh[VAL_W-1:0];
    end
    sts.busy = prod_v_r;
    sts.sat  = sat_pos || sat_neg;
  end

endmodule

>>> rtl/matrix_multiply_engine.sv
// a rejected write goes to S_ERR, which raises out_valid once the output register is free
// compute: each result element accumulates inner_size products through the shared multiply-accumulate
// throughput: writes one per cycle while idle; a compute run or a rejected write holds in_ready low
// reset: rst_n synchronous active low clears control and sets all size registers to 8
// reset: the A and B stores are not cleared and hold garbage until written
`timescale 1ns / 1ps

module matrix_multiply_engine import mme_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] a_rows_r, inner_size_r, b_cols_r;
  logic [CFG_W-1:0] m_dim, n_dim, p_dim;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0] i_last, j_last, k_last;
  logic [IDX_W-1:0] err_row_r, err_col_r;
  logic             rd_v_r;
  logic             out_valid_r;
  out_item_t        out_r;
  logic             out_free;
  logic             in_acc;
  logic             is_wr;
  logic             wr_bad;
  logic [CFG_W-1:0] rlim, clim;
  logic             a_we, b_we;
  logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
  logic [VAL_W-1:0] a_rdata, b_rdata;
  mac_ctl_t         mac_ctl;
  mac_sts_t         mac_sts;
  logic signed [VAL_W-1:0] mac_result;
  logic             emit_now;
  logic             elem_last;

  assign m_dim  = eff_dim(a_rows_r);
  assign n_dim  = eff_dim(inner_size_r);
  assign p_dim  = eff_dim(b_cols_r);
  assign i_last = IDX_W'(m_dim - CFG_W'(1));
  assign j_last = IDX_W'(p_dim - CFG_W'(1));
  assign k_last = IDX_W'(n_dim - CFG_W'(1));

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // write range check, store write enables and store addresses
  always_comb begin
    is_wr = (in_data.operation == OP_WRITE_A) || (in_data.operation == OP_WRITE_B);
    rlim  = (in_data.operation == OP_WRITE_A) ? m_dim : n_dim;
    clim  = (in_data.operation == OP_WRITE_A) ? n_dim : p_dim;
    wr_bad = ({1'b0, in_data.row_index} >= rlim) || ({1'b0, in_data.col_index} >= clim);
    a_we   = in_acc && (in_data.operation == OP_WRITE_A) && !wr_bad;
    b_we   = in_acc && (in_data.operation == OP_WRITE_B) && !wr_bad;
    wr_addr = store_addr(in_data.row_index, in_data.col_index);
    a_raddr = store_addr(i_r, k_r);
    b_raddr = store_addr(k_r, j_r);
  end

  mme_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (in_data.element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mme_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (in_data.element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign mac_ctl.clear = (state_r == S_READ) && (k_r == '0);
  assign mac_ctl.valid = rd_v_r;

  mme_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_val  (a_rdata),
    .b_val  (b_rdata),
    .sts    (mac_sts),
    .result (mac_result)
  );

  assign elem_last = (i_r == i_last) && (j_r == j_last);
  assign emit_now  = (state_r == S_EMIT) && out_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.operation == OP_COMPUTE) begin
            state_nxt = S_READ;
            i_nxt     = '0;
            j_nxt     = '0;
            k_nxt     = '0;
          end else if (is_wr && wr_bad) begin
            state_nxt = S_ERR;
          end
        end
      end
      S_READ: begin
        if (k_r == k_last) begin
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (!rd_v_r && !mac_sts.busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          k_nxt = '0;
          if (elem_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
            if (j_r == j_last) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      a_rows_r     <= CFG_RESET;
      inner_size_r <= CFG_RESET;
      b_cols_r     <= CFG_RESET;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_READ);
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (emit_now || ((state_r == S_ERR) && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_A_ROWS:     a_rows_r     <= cfg_data;
          REG_INNER_SIZE: inner_size_r <= cfg_data;
          REG_B_COLS:     b_cols_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result register and captured error indices
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_row_r <= in_data.row_index;
      err_col_r <= in_data.col_index;
    end
    if (emit_now) begin
      out_r.product_value <= mac_result;
      out_r.out_row       <= i_r;
      out_r.out_col       <= j_r;
      out_r.last_element  <= elem_last;
      out_r.saturated     <= mac_sts.sat;
      out_r.index_error   <= 1'b0;
    end else if ((state_r == S_ERR) && out_free) begin
      out_r.product_value <= '0;
      out_r.out_row       <= err_row_r;
      out_r.out_col       <= err_col_r;
      out_r.last_element  <= 1'b0;
      out_r.saturated     <= 1'b0;
      out_r.index_error   <= 1'b1;
    end
  end

  a_idle_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!mac_sts.busy && !rd_v_r))
    else $error("mac busy while idle");

  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.operation == OP_COMPUTE) |=> (state_r == S_READ))
    else $error("compute beat did not start a run");

  a_error_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.index_error) |-> (!out_data.last_element && !out_data.saturated))
    else $error("error beat carries compute flags");

  a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> ($past(state_r) == S_READ))
    else $error("read data valid without an issued read");

  a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (!rd_v_r && !mac_sts.busy))
    else $error("result taken before accumulation finished");

endmodule

>>> bench/matrix_multiply_engine_tb.sv
`timescale 1ns / 1ps

module matrix_multiply_engine_tb;
  import mme_pkg::*;

  localparam int ITEM_TARGET = 350;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_PRINTED = 30;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

  typedef struct {
    in_item_t data;
    int gap;
  } queued_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  matrix_multiply_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // sizes as last written
  logic [CFG_W-1:0] a_rows_reg = CFG_RESET;
  logic [CFG_W-1:0] inner_reg = CFG_RESET;
  logic [CFG_W-1:0] b_cols_reg = CFG_RESET;

  logic signed [VAL_W-1:0] mat_a [STORE_DEPTH];
  logic signed [VAL_W-1:0] mat_b [STORE_DEPTH];
  bit gen_a_set [STORE_DEPTH];
  bit gen_b_set [STORE_DEPTH];

  queued_item_t op_queue[$];
  out_item_t pending_products[$];

  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int ready_wait = 0;
  bit staged = 1'b0;
  in_item_t staged_item = '0;
  int gap_left = 0;

  int mismatch_count = 0;
  int items_pushed = 0;
  int items_accepted = 0;
  int beats_seen = 0;
  int compute_runs = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  function automatic int size_in_use(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return int'(v);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel) inside
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4: return VAL_W'($urandom_range(0, 32'h0003_FFFF));
      5, 6: return -VAL_W'($urandom_range(0, 32'h0003_FFFF));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("error: %s", msg);
  endtask

  task automatic apply_matrix_op(input in_item_t it);
    int m, n, p, rlim, clim;
    logic signed [71:0] acc, shifted;
    longint prod;
    out_item_t beat;
    m = size_in_use(a_rows_reg);
    n = size_in_use(inner_reg);
    p = size_in_use(b_cols_reg);
    case (it.operation) inside
      OP_WRITE_A, OP_WRITE_B: begin
        rlim = (it.operation == OP_WRITE_A) ? m : n;
        clim = (it.operation == OP_WRITE_A) ? n : p;
        if (it.row_index >= rlim || it.col_index >= clim) begin
          beat = '0;
          beat.out_row = it.row_index;
          beat.out_col = it.col_index;
          beat.index_error = 1'b1;
          pending_products.insert(pending_products.size(), beat);
        end else if (it.operation == OP_WRITE_A) begin
          mat_a[it.row_index * MAX_DIM + it.col_index] = it.element_value;
        end else begin
          mat_b[it.row_index * MAX_DIM + it.col_index] = it.element_value;
        end
      end
      OP_COMPUTE: begin
        compute_runs++;
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < p; j++) begin
            acc = '0;
            for (int k = 0; k < n; k++) begin
              prod = longint'(mat_a[i * MAX_DIM + k]) * longint'(mat_b[k * MAX_DIM + j]);
              acc = acc + prod;
            end
            shifted = acc >>> FRAC_BITS;
            beat = '0;
            if (shifted > SAT_HI) begin
              beat.product_value = 32'h7FFF_FFFF;
              beat.saturated = 1'b1;
            end else if (shifted < SAT_LO) begin
              beat.product_value = 32'h8000_0000;
              beat.saturated = 1'b1;
            end else begin
              beat.product_value = shifted[VAL_W-1:0];
            end
            beat.out_row = IDX_W'(i);
            beat.out_col = IDX_W'(j);
            beat.last_element = (i == m - 1) && (j == p - 1);
            pending_products.insert(pending_products.size(), beat);
          end
        end
      end
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk) begin : sender
    queued_item_t entry;
    if (!rst_n) begin
      in_valid <= 1'b0;
      staged <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_matrix_op(in_data);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (staged && gap_left == 0) begin
          in_valid <= 1'b1;
          in_data <= staged_item;
          staged <= 1'b0;
        end else if (staged) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          entry = op_queue.pop_front();
          if (entry.gap == 0) begin
            in_valid <= 1'b1;
            in_data <= entry.data;
          end else begin
            staged <= 1'b1;
            staged_item <= entry.data;
            gap_left <= entry.gap - 1;
            in_valid <= 1'b0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin : receiver
    int wait_draw;
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_wait <= 0;
      hold_left <= 0;
    end else begin
      wait_draw = ready_wait;
      if (out_valid && out_ready) begin
        if (pending_products.size() == 0) begin
          report_mismatch($sformatf("unexpected beat row %0d col %0d value %h",
                                    out_data.out_row, out_data.out_col, out_data.product_value));
        end else begin
          want = pending_products.pop_front();
          if (out_data.product_value !== want.product_value ||
              out_data.out_row !== want.out_row ||
              out_data.out_col !== want.out_col ||
              out_data.last_element !== want.last_element ||
              out_data.saturated !== want.saturated ||
              out_data.index_error !== want.index_error) begin
            report_mismatch($sformatf({"beat %0d got %h r%0d c%0d last %b sat %b err %b, ",
                                       "want %h r%0d c%0d last %b sat %b err %b"},
              beats_seen, out_data.product_value, out_data.out_row, out_data.out_col,
              out_data.last_element, out_data.saturated, out_data.index_error,
              want.product_value, want.out_row, want.out_col,
              want.last_element, want.saturated, want.index_error));
          end
        end
        beats_seen++;
        wait_draw = receiver_idle ? $urandom_range(0, 6) : 0;
      end
      if (hold_taken != hold_asked) begin
        hold_taken <= hold_taken + 1;
        hold_left <= LONG_HOLD;
        ready_wait <= wait_draw;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        ready_wait <= wait_draw;
        out_ready <= 1'b0;
      end else if (wait_draw > 0) begin
        ready_wait <= wait_draw - 1;
        out_ready <= 1'b0;
      end else begin
        ready_wait <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("error: cycle limit reached, %0d beats still expected", pending_products.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_A_ROWS: a_rows_reg = value;
      REG_INNER_SIZE: inner_reg = value;
      REG_B_COLS: b_cols_reg = value;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] inn,
                           input logic [CFG_W-1:0] bc);
    write_reg(REG_A_ROWS, ar);
    write_reg(REG_INNER_SIZE, inn);
    write_reg(REG_B_COLS, bc);
    @(negedge clk);
  endtask

  task automatic push_item(input logic [OP_W-1:0] op, input int row, input int col,
                           input logic [VAL_W-1:0] value);
    queued_item_t q;
    int m, n, p;
    m = size_in_use(a_rows_reg);
    n = size_in_use(inner_reg);
    p = size_in_use(b_cols_reg);
    q.data.operation = op;
    q.data.row_index = IDX_W'(row);
    q.data.col_index = IDX_W'(col);
    q.data.element_value = value;
    q.gap = sender_idle ? $urandom_range(0, 6) : 0;
    if (op == OP_WRITE_A && row < m && col < n) gen_a_set[row * MAX_DIM + col] = 1'b1;
    if (op == OP_WRITE_B && row < n && col < p) gen_b_set[row * MAX_DIM + col] = 1'b1;
    op_queue.insert(op_queue.size(), q);
    items_pushed++;
  endtask

  // writes whatever elements the next run reads but were never written, then queues the compute
  task automatic push_compute();
    int m, n, p;
    m = size_in_use(a_rows_reg);
    n = size_in_use(inner_reg);
    p = size_in_use(b_cols_reg);
    for (int i = 0; i < m; i++) begin
      for (int k = 0; k < n; k++) begin
        if (!gen_a_set[i * MAX_DIM + k]) push_item(OP_WRITE_A, i, k, pick_value());
      end
    end
    for (int k = 0; k < n; k++) begin
      for (int j = 0; j < p; j++) begin
        if (!gen_b_set[k * MAX_DIM + j]) push_item(OP_WRITE_B, k, j, pick_value());
      end
    end
    push_item(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
  endtask

  task automatic wait_idle();
    while (op_queue.size() != 0 || staged || in_valid || pending_products.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int phase, count, sel, m, n, p, rlim, clim, row, col;
    logic [OP_W-1:0] op;
    logic [CFG_W-1:0] sz [3];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 1x2 times 2x1
    set_sizes(4'd1, 4'd2, 4'd1);
    push_item(OP_WRITE_A, 0, 0, 32'h7FFF_FFFF);
    push_item(OP_WRITE_A, 0, 1, 32'h7FFF_FFFF);
    push_item(OP_WRITE_B, 0, 0, 32'h7FFF_FFFF);
    push_item(OP_WRITE_B, 1, 0, 32'h7FFF_FFFF);
    push_item(OP_COMPUTE, 0, 0, 32'h0);
    // negative sum that rounds down
    push_item(OP_WRITE_B, 0, 0, 32'h8000_0000);
    push_item(OP_COMPUTE, 7, 7, 32'hFFFF_FFFF);
    // sum beyond 64 bits
    push_item(OP_WRITE_A, 0, 0, 32'h8000_0000);
    push_item(OP_WRITE_A, 0, 1, 32'h8000_0000);
    push_item(OP_WRITE_B, 1, 0, 32'h8000_0000);
    push_item(OP_COMPUTE, 0, 0, 32'h0);
    // negative clip
    push_item(OP_WRITE_B, 0, 0, 32'h7FFF_FFFF);
    push_item(OP_WRITE_B, 1, 0, 32'h7FFF_FFFF);
    push_item(OP_COMPUTE, 0, 0, 32'h0);
    // minus one lsb
    push_item(OP_WRITE_A, 0, 0, 32'hFFFF_FFFF);
    push_item(OP_WRITE_A, 0, 1, 32'h0000_0000);
    push_item(OP_WRITE_B, 0, 0, 32'h0000_0001);
    push_item(OP_COMPUTE, 0, 0, 32'h0);
    // writes outside the size, unused operations and a compute
    push_item(OP_WRITE_A, 7, 7, 32'h1234_5678);
    push_item(OP_WRITE_A, 0, 2, 32'hFFFF_FFFF);
    push_item(OP_WRITE_B, 2, 0, 32'h0000_0000);
    push_item(OP_WRITE_B, 0, 7, 32'h5555_5555);
    push_item(OP_UNUSED, 7, 7, 32'hFFFF_FFFF);
    push_item(OP_UNUSED, 0, 0, 32'h0000_0000);
    push_item(OP_COMPUTE, 0, 0, 32'h0);
    wait_idle();

    phase = 0;
    while (items_pushed < ITEM_TARGET) begin
      sender_idle = (phase % 3) != 2;
      receiver_idle = (phase % 4) != 3;
      if (phase == 0) begin
        sz[0] = 4'd0;
        sz[1] = 4'd0;
        sz[2] = 4'd0;
      end else if (phase == 1) begin
        sz[0] = 4'd15;
        sz[1] = 4'd9;
        sz[2] = 4'd8;
      end else begin
        for (int r = 0; r < 3; r++) begin
          sel = $urandom_range(0, 5);
          sz[r] = (sel == 0) ? CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(1, 4));
        end
      end
      set_sizes(sz[0], sz[1], sz[2]);
      m = size_in_use(a_rows_reg);
      n = size_in_use(inner_reg);
      p = size_in_use(b_cols_reg);
      // long output stall while writes keep coming behind a compute
      if (phase == 2) begin
        push_compute();
        hold_asked++;
      end
      count = $urandom_range(8, 20);
      for (int t = 0; t < count; t++) begin
        sel = $urandom_range(0, 99);
        op = $urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A;
        rlim = (op == OP_WRITE_A) ? m : n;
        clim = (op == OP_WRITE_A) ? n : p;
        if (sel < 60) begin
          push_item(op, $urandom_range(0, rlim - 1), $urandom_range(0, clim - 1), pick_value());
        end else if (sel < 75 && (rlim < 8 || clim < 8)) begin
          if (rlim < 8 && (clim == 8 || $urandom_range(0, 1))) begin
            row = $urandom_range(rlim, 7);
            col = $urandom_range(0, 7);
          end else begin
            row = $urandom_range(0, 7);
            col = $urandom_range(clim, 7);
          end
          push_item(op, row, col, $urandom);
        end else if (sel < 82) begin
          push_item(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
        end else begin
          push_compute();
        end
      end
      push_compute();
      wait_idle();
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input beats, %0d compute runs, %0d result beats checked",
             items_accepted, compute_runs, beats_seen);
    $display("%0d register writes over %0d size settings plus the directed one",
             reg_writes, phase);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
